### hw/rtl/rptw_pkg.sv
// ----------------------------------------------------------------------------
// rptw_pkg
// shared types, sizes and helper functions of the radix page table walker
// ----------------------------------------------------------------------------
package rptw_pkg;

   function automatic int floor_log2(int value);
      int v;
      int r;
      v = value;
      r = 0;
      for (int i = 0; i < 32; i++) begin
         if (v > 1 && r < 31) begin
            v = v >> 1;
            r = r + 1;
         end
      end
      return r;
   endfunction

   localparam int NODE_COUNT        = 16;
   localparam int ENTRY_COUNT       = 65536;
   localparam int UPPER_LEVEL_SLOTS = 4096;
   localparam int LEAF_LEVEL_SLOTS  = 256;

   localparam int UPPER_BITS  = floor_log2(UPPER_LEVEL_SLOTS);
   localparam int LEAF_BITS   = floor_log2(LEAF_LEVEL_SLOTS);
   localparam int TOTAL_BITS  = 2 * UPPER_BITS + LEAF_BITS;
   localparam int SLOT_STRIDE = (UPPER_LEVEL_SLOTS > LEAF_LEVEL_SLOTS) ?
                                UPPER_LEVEL_SLOTS : LEAF_LEVEL_SLOTS;
   localparam int STORE_DEPTH = NODE_COUNT * SLOT_STRIDE;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int NODE_W      = $clog2(NODE_COUNT);
   localparam int NODE_CNT_W  = $clog2(NODE_COUNT + 1);
   localparam int ENTRY_CNT_W = $clog2(ENTRY_COUNT + 1);
   localparam int IX_W        = $clog2((NODE_COUNT > ENTRY_COUNT) ? NODE_COUNT : ENTRY_COUNT);
   localparam int FB_W        = 6;
   localparam int HANDLE_W    = 16;

   localparam logic [1:0] LVL_TOP  = 2'd0;
   localparam logic [1:0] LVL_MID  = 2'd1;
   localparam logic [1:0] LVL_LEAF = 2'd2;

   localparam logic CSR_ADDR_SPACE  = 1'b0;
   localparam logic CSR_PAGE_OFFSET = 1'b1;

   typedef struct packed {
      logic [31:0] virtual_frame;
      logic [1:0]  ref_kind;
   } req_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] entry_handle;
      logic                first_access;
      logic [1:0]          kind_echo;
      logic                pool_exhausted;
   } rsp_type;

   // one node slot: valid, child or entry index, and that index modulo the node count
   typedef struct packed {
      logic              valid;
      logic [IX_W-1:0]   index;
      logic [NODE_W-1:0] node;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   typedef struct packed {
      logic clear_step;
      logic start;
      logic step;
      logic deliver;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic walk_end;
      logic out_free;
   } dp_sts_type;

   typedef enum logic [3:0] {
      ST_CLEAR   = 4'b0001,
      ST_IDLE    = 4'b0010,
      ST_WALK    = 4'b0100,
      ST_DELIVER = 4'b1000
   } state_type;

   // frame width: saturated to 1..32, then capped at the table depth
   function automatic logic [FB_W-1:0] frame_bits(logic [5:0] asw, logic [4:0] pow);
      logic [6:0] fb;
      if (asw <= {1'b0, pow}) begin
         fb = 7'd1;
      end else begin
         fb = 7'(asw) - 7'(pow);
      end
      if (fb > 7'd32) begin
         fb = 7'd32;
      end
      if (fb > 7'(TOTAL_BITS)) begin
         fb = 7'(TOTAL_BITS);
      end
      return FB_W'(fb);
   endfunction

   function automatic logic [6:0] level_bits(logic [1:0] lvl);
      logic [6:0] lb;
      case (lvl)
         LVL_TOP, LVL_MID: lb = 7'(UPPER_BITS);
         default:          lb = 7'(LEAF_BITS);
      endcase
      return lb;
   endfunction

   function automatic logic [6:0] level_base(logic [1:0] lvl);
      logic [6:0] cum;
      case (lvl)
         LVL_TOP: cum = 7'd0;
         LVL_MID: cum = 7'(UPPER_BITS);
         default: cum = 7'(2 * UPPER_BITS);
      endcase
      return cum;
   endfunction

   function automatic logic is_leaf(logic [FB_W-1:0] fb, logic [1:0] lvl);
      return (lvl == LVL_LEAF) || ((level_base(lvl) + level_bits(lvl)) >= 7'(fb));
   endfunction

   // store address of the slot that a level of the walk reads
   function automatic logic [ADDR_W-1:0] slot_addr(logic [31:0]       frame,
                                                   logic [FB_W-1:0]   fb,
                                                   logic [1:0]        lvl,
                                                   logic [NODE_W-1:0] node);
      logic [6:0]  fbx;
      logic [6:0]  cum;
      logic [6:0]  lb;
      logic [6:0]  lg;
      logic [6:0]  sh;
      logic [31:0] mask;
      logic [31:0] idx;
      fbx = 7'(fb);
      cum = level_base(lvl);
      lb  = level_bits(lvl);
      if (fbx >= cum + lb) begin
         lg = lb;
         sh = fbx - cum - lb;
      end else if (fbx > cum) begin
         lg = fbx - cum;
         sh = 7'd0;
      end else begin
         lg = 7'd0;
         sh = 7'd0;
      end
      mask = (32'd1 << lg) - 32'd1;
      idx  = (frame >> sh) & mask;
      return ADDR_W'(int'(node) * SLOT_STRIDE + int'(idx));
   endfunction

   function automatic logic [HANDLE_W-1:0] low_handle(logic [IX_W-1:0] ix);
      logic [31:0] wide;
      wide = 32'(ix);
      return wide[HANDLE_W-1:0];
   endfunction

endpackage

### hw/rtl/rptw_ram.sv
// ----------------------------------------------------------------------------
// rptw_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rptw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write-through when both ports hit the same word
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (we && (waddr == raddr)) begin
         rdata_ff <= wdata;
      end else begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/rptw_ctrl.sv
// ----------------------------------------------------------------------------
// rptw_ctrl
// walk sequencer: clearing pass, request intake, level steps, delivery
// ----------------------------------------------------------------------------
module rptw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output rptw_pkg::dp_cmd_type cmd,
   input  rptw_pkg::dp_sts_type sts
);
   import rptw_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (sts.walk_end) state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign cmd.clear_step = (state_ff == ST_CLEAR);
   assign cmd.start      = (state_ff == ST_IDLE) && req_valid;
   assign cmd.step       = (state_ff == ST_WALK);
   assign cmd.deliver    = (state_ff == ST_DELIVER) && sts.out_free;

endmodule

### hw/rtl/rptw_datapath.sv
// ----------------------------------------------------------------------------
// rptw_datapath
// node store, allocation pools, level address generation and result register
// ----------------------------------------------------------------------------
module rptw_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [rptw_pkg::FB_W-1:0]  frame_width,
   input  rptw_pkg::req_type          req_data,
   input  rptw_pkg::dp_cmd_type       cmd,
   output rptw_pkg::dp_sts_type       sts,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rptw_pkg::rsp_type          rsp_data
);
   import rptw_pkg::*;

   // transaction context
   logic [31:0]         frame_ff,    frame_in;
   logic [1:0]          kind_ff,     kind_in;
   logic [1:0]          level_ff,    level_in;
   logic [ADDR_W-1:0]   cur_addr_ff, cur_addr_in;

   // pools
   logic [NODE_CNT_W-1:0]  next_node_ff,  next_node_in;
   logic [ENTRY_CNT_W-1:0] next_entry_ff, next_entry_in;
   logic [NODE_W-1:0]      entry_mod_ff,  entry_mod_in;
   logic [ADDR_W-1:0]      clear_cnt_ff,  clear_cnt_in;

   // walk result and output register
   logic [HANDLE_W-1:0] res_handle_ff, res_handle_in;
   logic                res_first_ff,  res_first_in;
   logic                res_fail_ff,   res_fail_in;
   logic                rsp_valid_ff,  rsp_valid_in;
   rsp_type             rsp_data_ff,   rsp_data_in;

   // store ports
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [SLOT_W-1:0] ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [SLOT_W-1:0] ram_rdata;

   slot_type          slot;
   slot_type          new_slot;
   logic              leaf;
   logic              node_full;
   logic              entry_full;
   logic [NODE_W-1:0] child;
   logic [1:0]        next_level;
   logic [ADDR_W-1:0] next_addr;

   rptw_ram #(
      .WIDTH(SLOT_W),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign slot       = slot_type'(ram_rdata);
   assign leaf       = is_leaf(frame_width, level_ff);
   assign node_full  = (next_node_ff == NODE_CNT_W'(NODE_COUNT));
   assign entry_full = (next_entry_ff == ENTRY_CNT_W'(ENTRY_COUNT));
   assign next_level = 2'(level_ff + 2'd1);

   always_comb begin
      frame_in      = frame_ff;
      kind_in       = kind_ff;
      level_in      = level_ff;
      cur_addr_in   = cur_addr_ff;
      next_node_in  = next_node_ff;
      next_entry_in = next_entry_ff;
      entry_mod_in  = entry_mod_ff;
      clear_cnt_in  = clear_cnt_ff;
      res_handle_in = res_handle_ff;
      res_first_in  = res_first_ff;
      res_fail_in   = res_fail_ff;
      ram_we        = 1'b0;
      ram_waddr     = cur_addr_ff;
      new_slot      = '0;
      ram_raddr     = cur_addr_ff;
      child         = slot.node;
      next_addr     = cur_addr_ff;

      if (cmd.clear_step) begin
         ram_we       = 1'b1;
         ram_waddr    = clear_cnt_ff;
         clear_cnt_in = ADDR_W'(clear_cnt_ff + 1'b1);
      end

      if (cmd.start) begin
         frame_in    = req_data.virtual_frame;
         kind_in     = req_data.ref_kind;
         level_in    = LVL_TOP;
         next_addr   = slot_addr(req_data.virtual_frame, frame_width, LVL_TOP, '0);
         ram_raddr   = next_addr;
         cur_addr_in = next_addr;
      end

      if (cmd.step) begin
         if (leaf) begin
            res_first_in  = 1'b0;
            res_fail_in   = 1'b0;
            res_handle_in = '0;
            if (slot.valid) begin
               res_handle_in = low_handle(slot.index);
            end else if (entry_full) begin
               res_fail_in = 1'b1;
            end else begin
               ram_we         = 1'b1;
               new_slot.valid = 1'b1;
               new_slot.index = IX_W'(next_entry_ff);
               new_slot.node  = entry_mod_ff;
               res_handle_in  = low_handle(IX_W'(next_entry_ff));
               res_first_in   = 1'b1;
               next_entry_in  = ENTRY_CNT_W'(next_entry_ff + 1'b1);
               entry_mod_in   = (entry_mod_ff == NODE_W'(NODE_COUNT - 1)) ?
                                '0 : NODE_W'(entry_mod_ff + 1'b1);
            end
         end else begin
            if (!slot.valid) begin
               if (node_full) begin
                  res_fail_in   = 1'b1;
                  res_first_in  = 1'b0;
                  res_handle_in = '0;
               end else begin
                  // new interior node, linked before descending
                  ram_we         = 1'b1;
                  new_slot.valid = 1'b1;
                  new_slot.index = IX_W'(next_node_ff);
                  new_slot.node  = NODE_W'(next_node_ff);
                  child          = NODE_W'(next_node_ff);
                  next_node_in   = NODE_CNT_W'(next_node_ff + 1'b1);
               end
            end
            next_addr   = slot_addr(frame_ff, frame_width, next_level, child);
            ram_raddr   = next_addr;
            cur_addr_in = next_addr;
            level_in    = next_level;
         end
      end
   end

   assign ram_wdata = ram_we && !cmd.clear_step ? SLOT_W'(new_slot) : '0;

   assign sts.clear_last = (clear_cnt_ff == ADDR_W'(STORE_DEPTH - 1));
   assign sts.walk_end   = leaf || (!slot.valid && node_full);
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.deliver) begin
         rsp_data_in.entry_handle   = res_handle_ff;
         rsp_data_in.first_access   = res_first_ff;
         rsp_data_in.kind_echo      = kind_ff;
         rsp_data_in.pool_exhausted = res_fail_ff;
         rsp_valid_in               = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_node_ff  <= NODE_CNT_W'(1);
         next_entry_ff <= '0;
         entry_mod_ff  <= '0;
         clear_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         next_node_ff  <= next_node_in;
         next_entry_ff <= next_entry_in;
         entry_mod_ff  <= entry_mod_in;
         clear_cnt_ff  <= clear_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff      <= frame_in;
      kind_ff       <= kind_in;
      level_ff      <= level_in;
      cur_addr_ff   <= cur_addr_in;
      res_handle_ff <= res_handle_in;
      res_first_ff  <= res_first_in;
      res_fail_ff   <= res_fail_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### hw/rtl/radix_page_table_walker.sv
// ----------------------------------------------------------------------------
// radix_page_table_walker
// radix page table walk with on-demand node and entry allocation
// ----------------------------------------------------------------------------
// Each transaction carries a virtual frame number and a reference kind and
// returns one result: the page entry handle, a first-access flag, the kind and
// a pool-exhausted flag. The table has up to three levels (12, 12 and 8 index
// bits), the level that reaches the frame width (address_space_width minus
// page_offset_width, held to 1..32) is trimmed and acts as the leaf. Missing
// nodes and entries are allocated as the walk goes. A transaction has an
// intake step, one node store read per level walked, 1 to 3 (the read of the
// next level is issued in the same cycle as any allocation write), and a step
// that loads the result register once the result channel is free. The result
// register lets a new transaction enter while the last result waits. After
// reset the node store is cleared one slot a cycle, during which no request
// is taken; configuration writes are accepted throughout.
// ----------------------------------------------------------------------------
module radix_page_table_walker (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  rptw_pkg::req_type req_data,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rptw_pkg::rsp_type rsp_data,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import rptw_pkg::*;

   // configuration registers
   logic [5:0]      asw_ff, asw_in;
   logic [4:0]      pow_ff, pow_in;
   logic            csr_write;
   logic [FB_W-1:0] frame_width;

   dp_cmd_type cmd;
   dp_sts_type sts;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      asw_in = asw_ff;
      pow_in = pow_ff;
      if (csr_write) begin
         case (paddr[2])
            CSR_ADDR_SPACE:  asw_in = pwdata[5:0];
            CSR_PAGE_OFFSET: pow_in = pwdata[4:0];
            default: begin
               asw_in = asw_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_ADDR_SPACE:  prdata = {26'd0, asw_ff};
         CSR_PAGE_OFFSET: prdata = {27'd0, pow_ff};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         asw_ff <= 6'd32;
         pow_ff <= 5'd12;
      end else begin
         asw_ff <= asw_in;
         pow_ff <= pow_in;
      end
   end

   // level widths follow from the saturated frame width
   assign frame_width = frame_bits(asw_ff, pow_ff);

   rptw_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .cmd      (cmd),
      .sts      (sts)
   );

   rptw_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .frame_width(frame_width),
      .req_data   (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
